### rtl/core/bar_raster_scan_sequencer_top_macros.svh
// Assertion macros shared by the bar raster scan sequencer RTL.
`ifndef BAR_RASTER_SCAN_SEQUENCER_TOP_MACROS_SVH
`define BAR_RASTER_SCAN_SEQUENCER_TOP_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define BRSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define BRSS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/brss_pkg.sv
// Types, constants and unit tables of the bar raster scan sequencer.
package brss_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int OFFSET_W        = 18;
    localparam int S_TDATA_W       = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCAN_WIDTH    = 3'd0,
        REG_BAR_SPACING   = 3'd1,
        REG_BAR_COUNT     = 3'd2,
        REG_LEFT_TO_RIGHT = 3'd3,
        REG_VERTICAL_BARS = 3'd4,
        REG_REF_AZIMUTH   = 3'd5,
        REG_REF_ELEVATION = 3'd6
    } brss_reg_idx_t;

    typedef enum logic [1:0] {
        PH_RESET    = 2'd0,
        PH_TO_START = 2'd1,
        PH_SWEEP    = 2'd2
    } brss_phase_t;

    typedef struct packed {
        logic [15:0]        scan_width;
        logic [14:0]        bar_spacing;
        logic [2:0]         bar_count;
        logic               left_to_right;
        logic               vertical_bars;
        logic signed [15:0] ref_azimuth;
        logic signed [15:0] ref_elevation;
    } brss_cfg_t;

    typedef struct packed {
        logic        fast_slew;
        logic        bar_started;
        logic        bar_ended;
        logic [2:0]  current_bar;
        brss_phase_t scan_phase;
        logic        reversing;
    } brss_flags_t;

    // [count-1][bar-1][side][0: across sign, 1: bar half-units]
    localparam logic signed [2:0] UNIT_TAB [4][4][2][2] = '{
        '{ '{'{-3'sd1, 3'sd0}, '{ 3'sd1, 3'sd0}}, '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}},
           '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}}, '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}} },
        '{ '{'{-3'sd1, 3'sd1}, '{ 3'sd1, 3'sd1}}, '{'{ 3'sd1,-3'sd1}, '{-3'sd1,-3'sd1}},
           '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}}, '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}} },
        '{ '{'{-3'sd1, 3'sd2}, '{ 3'sd1, 3'sd2}}, '{'{ 3'sd1, 3'sd0}, '{-3'sd1, 3'sd0}},
           '{'{-3'sd1,-3'sd2}, '{ 3'sd1,-3'sd2}}, '{'{ 3'sd0, 3'sd0}, '{ 3'sd0, 3'sd0}} },
        '{ '{'{-3'sd1, 3'sd3}, '{ 3'sd1, 3'sd3}}, '{'{ 3'sd1, 3'sd1}, '{-3'sd1, 3'sd1}},
           '{'{-3'sd1,-3'sd1}, '{ 3'sd1,-3'sd1}}, '{'{ 3'sd1,-3'sd3}, '{-3'sd1,-3'sd3}} }
    };

    // Clamp the programmed bar count into 1..4.
    function automatic logic [2:0] used_count(input logic [2:0] cnt);
        logic [2:0] res;
        if (cnt == 3'd0) begin
            res = 3'd1;
        end else if (cnt > 3'd4) begin
            res = 3'd4;
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

### rtl/core/bar_raster_scan_sequencer_top.sv
// Bar raster scan sequencer: servo tick stream in, commanded angle stream out.
//
// Each transfer on the s_ channel is one servo tick (positioned, at_limits,
// restart). The block answers every tick with exactly one transfer on the
// m_ channel carrying the commanded azimuth and elevation, saturated to
// ANGLE_WIDTH signed bits, and the scan status flags.
// The tick lands in the input register at the s_ transfer; when the result
// register is free, the table, shift-add and saturating-add logic loads it
// and m_tvalid rises, and the result transfers on m_ from there. Each tick
// thus passes the input register and then the result register.
// Throughput is one tick per cycle while the receiver keeps m_tready high.
// s_tready drops only while both registers are full and m_tready is low, so
// a stalled receiver holds the pending result and backs up one tick at most.
// Synchronous reset (aresetn low) empties both registers, returns the scan
// to the reset phase on bar 1 and restores the register defaults.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
// clock edge; issue them only while no tick is in flight.
`include "bar_raster_scan_sequencer_top_macros.svh"

module bar_raster_scan_sequencer_top #(
    parameter int  ANGLE_WIDTH = brss_pkg::ANGLE_WIDTH_DEF,
    localparam int M_TDATA_W   = ((2 * ANGLE_WIDTH + 9 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: positioned, at_limits, restart, zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [brss_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: cmd_azimuth, cmd_elevation, fast_slew, bar_started, bar_ended,
    //          current_bar, scan_phase, reversing, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [brss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [brss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int PAD_W = M_TDATA_W - (2 * ANGLE_WIDTH + 9);

    brss_pkg::brss_cfg_t   cfg;
    logic                  clr_reverse;
    brss_pkg::brss_flags_t flags;
    logic signed [ANGLE_WIDTH-1:0] cmd_az, cmd_el;

    logic       in_valid_reg, in_valid_next;
    logic [2:0] in_data_reg;
    logic       out_valid_reg, out_valid_next;
    logic signed [ANGLE_WIDTH-1:0] out_az_reg, out_el_reg;
    brss_pkg::brss_flags_t         out_flags_reg;
    logic       out_free, step;

    assign out_free = ~out_valid_reg | m_tready;
    assign step     = in_valid_reg & out_free;
    assign s_tready = ~in_valid_reg | out_free;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    brss_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cfg         (cfg),
        .clr_reverse (clr_reverse)
    );

    brss_core #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .positioned    (in_data_reg[0]),
        .at_limits     (in_data_reg[1]),
        .restart       (in_data_reg[2]),
        .cfg           (cfg),
        .clr_reverse   (clr_reverse),
        .cmd_azimuth   (cmd_az),
        .cmd_elevation (cmd_el),
        .flags         (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[2:0];
        end
        if (step) begin
            out_az_reg    <= cmd_az;
            out_el_reg    <= cmd_el;
            out_flags_reg <= flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}},
                       out_flags_reg.reversing,
                       out_flags_reg.scan_phase,
                       out_flags_reg.current_bar,
                       out_flags_reg.bar_ended,
                       out_flags_reg.bar_started,
                       out_flags_reg.fast_slew,
                       out_el_reg,
                       out_az_reg};

    `BRSS_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid && s_tready, "reset left data in flight")
    `BRSS_ASSERT(a_step_fills_out, step |=> m_tvalid, "processed tick produced no result")
    `BRSS_ASSERT(a_phase_after_tick, m_tvalid |-> (out_flags_reg.scan_phase == brss_pkg::PH_TO_START || out_flags_reg.scan_phase == brss_pkg::PH_SWEEP), "result left in reset phase")
    `BRSS_ASSERT(a_single_event, m_tvalid |-> !(out_flags_reg.bar_started && out_flags_reg.bar_ended), "bar start and end in one tick")
    `BRSS_ASSERT(a_bar_range, m_tvalid |-> (out_flags_reg.current_bar != 3'd0 && out_flags_reg.current_bar <= 3'd4), "bar number out of range")

endmodule

### rtl/core/brss_cfg.sv
// Configuration register file of the bar raster scan sequencer.
module brss_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [brss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [brss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output brss_pkg::brss_cfg_t               cfg,
    output logic                              clr_reverse
);

    brss_pkg::brss_cfg_t cfg_reg;
    brss_pkg::brss_cfg_t cfg_next;
    logic [2:0]          cnt_used;

    always_comb begin
        cfg_next    = cfg_reg;
        clr_reverse = 1'b0;
        cnt_used    = brss_pkg::used_count(cfg_wdata[2:0]);
        if (cfg_wr_en) begin
            case (brss_pkg::brss_reg_idx_t'(cfg_index))
                brss_pkg::REG_SCAN_WIDTH:    cfg_next.scan_width    = cfg_wdata;
                brss_pkg::REG_BAR_SPACING:   cfg_next.bar_spacing   = cfg_wdata[14:0];
                brss_pkg::REG_BAR_COUNT: begin
                    cfg_next.bar_count = cfg_wdata[2:0];
                    // an even raster never runs backwards
                    clr_reverse = ~cnt_used[0];
                end
                brss_pkg::REG_LEFT_TO_RIGHT: cfg_next.left_to_right = cfg_wdata[0];
                brss_pkg::REG_VERTICAL_BARS: cfg_next.vertical_bars = cfg_wdata[0];
                brss_pkg::REG_REF_AZIMUTH:   cfg_next.ref_azimuth   = $signed(cfg_wdata);
                brss_pkg::REG_REF_ELEVATION: cfg_next.ref_elevation = $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{scan_width:    16'd0,
                         bar_spacing:   15'd0,
                         bar_count:     3'd1,
                         left_to_right: 1'b1,
                         vertical_bars: 1'b0,
                         ref_azimuth:   16'sd0,
                         ref_elevation: 16'sd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/brss_core.sv
// Scan state registers and the per-tick next-state and angle logic.
module brss_core #(
    parameter int ANGLE_WIDTH = brss_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          positioned,
    input  logic                          at_limits,
    input  logic                          restart,
    input  brss_pkg::brss_cfg_t           cfg,
    input  logic                          clr_reverse,
    output logic signed [ANGLE_WIDTH-1:0] cmd_azimuth,
    output logic signed [ANGLE_WIDTH-1:0] cmd_elevation,
    output brss_pkg::brss_flags_t         flags
);

    localparam int OW    = brss_pkg::OFFSET_W;
    localparam int SUM_W = OW + 1;
    localparam int EXT_W = ((ANGLE_WIDTH > SUM_W) ? ANGLE_WIDTH : SUM_W) + 1;
    localparam logic signed [EXT_W-1:0] ANG_HI =
        {{(EXT_W-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] ANG_LO = ~ANG_HI;

    brss_pkg::brss_phase_t phase_reg, phase_next, phase_cur;
    logic [2:0]            bar_reg, bar_next;
    logic                  rev_reg, rev_next;
    logic                  slew_reg, slew_next;
    logic signed [OW-1:0]  off_p_reg, off_p_next;
    logic signed [OW-1:0]  off_s_reg, off_s_next;
    logic                  started, ended, ready;

    logic [2:0] nb, adv_bar, row;
    logic       adv_rev;
    logic [2:0] pos_bar;
    logic       pos_rev, pos_side, load_pos;
    logic [1:0] nb_m1, row_m1;
    logic signed [2:0] xs, yh;
    logic       x_neg;
    logic [1:0] y_abs;
    logic [16:0] y_mag;
    logic signed [OW-1:0] x_val, y_val, x1, y1, pos_p, pos_s;

    assign nb    = brss_pkg::used_count(cfg.bar_count);
    assign nb_m1 = 2'(nb - 3'd1);
    assign ready = positioned | at_limits;
    assign phase_cur = restart ? brss_pkg::PH_RESET : phase_reg;

    // Next bar by the odd/even rule.
    always_comb begin
        adv_bar = bar_reg;
        adv_rev = rev_reg;
        if (nb[0]) begin
            if (nb == 3'd1) begin
                adv_rev = ~rev_reg;
            end else if (bar_reg >= nb) begin
                adv_rev = 1'b1;
                adv_bar = nb - 3'd1;
            end else if (rev_reg && bar_reg > 3'd1) begin
                adv_bar = bar_reg - 3'd1;
            end else begin
                adv_bar = (bar_reg < 3'd1) ? 3'd2 : bar_reg + 3'd1;
                adv_rev = 1'b0;
            end
        end else begin
            adv_rev = 1'b0;
            adv_bar = ({1'b0, bar_reg} + 4'd1 > {1'b0, nb}) ? 3'd1 : bar_reg + 3'd1;
        end
    end

    // Phase sequencing; selects which bar end to load.
    always_comb begin
        phase_next = phase_cur;
        bar_next   = bar_reg;
        rev_next   = rev_reg;
        slew_next  = slew_reg;
        started    = 1'b0;
        ended      = 1'b0;
        load_pos   = 1'b0;
        pos_bar    = bar_reg;
        pos_rev    = rev_reg;
        pos_side   = 1'b0;
        case (phase_cur)
            brss_pkg::PH_TO_START: begin
                if (ready) begin
                    started    = 1'b1;
                    load_pos   = 1'b1;
                    pos_side   = 1'b1;
                    phase_next = brss_pkg::PH_SWEEP;
                    slew_next  = 1'b0;
                end
            end
            brss_pkg::PH_SWEEP: begin
                if (ready) begin
                    ended      = 1'b1;
                    load_pos   = 1'b1;
                    pos_bar    = adv_bar;
                    pos_rev    = adv_rev;
                    bar_next   = adv_bar;
                    rev_next   = adv_rev;
                    phase_next = brss_pkg::PH_TO_START;
                    slew_next  = 1'b1;
                end
            end
            default: begin
                load_pos   = 1'b1;
                pos_bar    = 3'd1;
                bar_next   = 3'd1;
                phase_next = brss_pkg::PH_TO_START;
                slew_next  = 1'b1;
            end
        endcase
    end

    // Bar endpoint from the unit table, scaled by half width and half spacing.
    always_comb begin
        if (pos_bar < 3'd1) begin
            row = 3'd1;
        end else if (pos_bar > nb) begin
            row = nb;
        end else begin
            row = pos_bar;
        end
        row_m1 = 2'(row - 3'd1);
        xs     = brss_pkg::UNIT_TAB[nb_m1][row_m1][pos_side][0];
        yh     = brss_pkg::UNIT_TAB[nb_m1][row_m1][pos_side][1];
        x_neg  = xs[2] ^ ~cfg.left_to_right ^ ((nb == 3'd1) & pos_rev);
        if (xs == 3'sd0) begin
            x_val = '0;
        end else if (x_neg) begin
            x_val = -$signed({2'b00, cfg.scan_width});
        end else begin
            x_val = $signed({2'b00, cfg.scan_width});
        end
        y_abs = yh[2] ? 2'(-yh) : 2'(yh);
        y_mag = (y_abs[0] ? {2'b00, cfg.bar_spacing} : 17'd0)
              + (y_abs[1] ? {1'b0, cfg.bar_spacing, 1'b0} : 17'd0);
        y_val = yh[2] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
        // arithmetic shift rounds the halving toward minus infinity
        x1 = x_val >>> 1;
        y1 = y_val >>> 1;
        pos_p = cfg.vertical_bars ? y1 : x1;
        pos_s = cfg.vertical_bars ? x1 : y1;
        off_p_next = load_pos ? pos_p : off_p_reg;
        off_s_next = load_pos ? pos_s : off_s_reg;
    end

    function automatic logic signed [ANGLE_WIDTH-1:0] sat_add(
        input logic signed [15:0] ref_ang,
        input logic signed [OW-1:0] off
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] clp;
        sum = SUM_W'(ref_ang) + SUM_W'(off);
        ext = EXT_W'(sum);
        if (ext > ANG_HI) begin
            clp = ANG_HI;
        end else if (ext < ANG_LO) begin
            clp = ANG_LO;
        end else begin
            clp = ext;
        end
        return ANGLE_WIDTH'(clp);
    endfunction

    assign cmd_azimuth   = sat_add(cfg.ref_azimuth, off_p_next);
    assign cmd_elevation = sat_add(cfg.ref_elevation, off_s_next);

    assign flags.fast_slew   = slew_next;
    assign flags.bar_started = started;
    assign flags.bar_ended   = ended;
    assign flags.current_bar = bar_next;
    assign flags.scan_phase  = phase_next;
    assign flags.reversing   = rev_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= brss_pkg::PH_RESET;
            bar_reg   <= 3'd1;
            rev_reg   <= 1'b0;
            slew_reg  <= 1'b0;
            off_p_reg <= '0;
            off_s_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bar_reg   <= bar_next;
            rev_reg   <= rev_next;
            slew_reg  <= slew_next;
            off_p_reg <= off_p_next;
            off_s_reg <= off_s_next;
        end else if (clr_reverse) begin
            rev_reg <= 1'b0;
        end
    end

endmodule
